FILE: rtl/core/dvtp_pkg.sv
// dvtp_pkg: shared constants and types for the delta varint time packer.
// No dependencies; compile first.
`timescale 1ns / 1ps

package dvtp_pkg;

   localparam int unsigned TIME_WIDTH   = 64;
   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned NIBBLE_WIDTH = 4;
   localparam int unsigned PAY_WIDTH    = TIME_WIDTH - NIBBLE_WIDTH;
   localparam int unsigned PAY_BYTES    = TIME_WIDTH / BYTE_WIDTH;
   localparam int unsigned LEN_WIDTH    = $clog2(PAY_BYTES);
   localparam int unsigned IDX_WIDTH    = $clog2(PAY_BYTES + 1);

   localparam logic [7:0] SIGN_BIT_MASK   = 8'h80;
   localparam logic [7:0] LOW_NIBBLE_MASK = 8'h0f;
   localparam logic [7:0] SIZE_STEP       = 8'h10;

   typedef struct packed {
      logic                  valid;
      logic [TIME_WIDTH-1:0] diff;
   } delta_type;

endpackage

FILE: rtl/core/dvtp_if.sv
// dvtp_if: request and response channel interfaces (valid/ready handshake).
// No dependencies.
`timescale 1ns / 1ps

interface dvtp_req_if;
   logic        valid;
   logic        ready;
   logic signed [63:0] timestamp;

   modport source (output valid, output timestamp, input ready);
   modport sink   (input valid, input timestamp, output ready);
endinterface

interface dvtp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/dvtp_delta.sv
// dvtp_delta: input register stage; holds the previous timestamp and
// registers the modulo-2^64 difference. Depends on dvtp_pkg, dvtp_if.
`timescale 1ns / 1ps

module dvtp_delta (
   input  logic                clock,
   input  logic                reset,
   dvtp_req_if.sink            req_ch,
   output dvtp_pkg::delta_type link,
   input  logic                link_ready
);
   import dvtp_pkg::*;

   logic                  valid_ff, valid_in;
   logic [TIME_WIDTH-1:0] diff_ff, diff_in;
   logic [TIME_WIDTH-1:0] prev_ff, prev_in;
   logic                  accept;

   assign req_ch.ready = !valid_ff || link_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      diff_in  = diff_ff;
      prev_in  = prev_ff;
      if (accept) begin
         valid_in = 1'b1;
         diff_in  = TIME_WIDTH'(unsigned'(req_ch.timestamp) - prev_ff);
         prev_in  = unsigned'(req_ch.timestamp);
      end else if (link_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         prev_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         prev_ff  <= prev_in;
      end
      diff_ff <= diff_in;
   end

   assign link.valid = valid_ff;
   assign link.diff  = diff_ff;

endmodule

FILE: rtl/core/dvtp_serializer.sv
// dvtp_serializer: sign/magnitude encode of one delta and byte-wide output.
// Depends on dvtp_pkg, dvtp_if.
`timescale 1ns / 1ps

module dvtp_serializer (
   input  logic                clock,
   input  logic                reset,
   input  dvtp_pkg::delta_type link,
   output logic                link_ready,
   dvtp_rsp_if.source          rsp_ch
);
   import dvtp_pkg::*;

   logic                  neg;
   logic [TIME_WIDTH-1:0] mag;
   logic [PAY_WIDTH-1:0]  pay;
   logic [TIME_WIDTH-1:0] pay_ext;
   logic [LEN_WIDTH-1:0]  len_m1;
   logic [7:0]            hdr;

   logic                  valid_ff, valid_in;
   logic [IDX_WIDTH-1:0]  idx_ff, idx_in;
   logic [LEN_WIDTH-1:0]  len_ff, len_in;
   logic [7:0]            hdr_ff, hdr_in;
   logic [PAY_WIDTH-1:0]  pay_ff, pay_in;

   logic                  fire, last;
   logic [LEN_WIDTH-1:0]  byte_sel;
   logic [TIME_WIDTH-1:0] pay_ff_ext;

   // encode
   always_comb begin
      neg     = link.diff[TIME_WIDTH-1];
      mag     = neg ? TIME_WIDTH'(~link.diff + 1'b1) : link.diff;
      pay     = mag[TIME_WIDTH-1:NIBBLE_WIDTH];
      pay_ext = {{NIBBLE_WIDTH{1'b0}}, pay};
      len_m1  = '0;
      for (int k = 1; k < PAY_BYTES; k++) begin
         if (|pay_ext[k*BYTE_WIDTH +: BYTE_WIDTH]) len_m1 = LEN_WIDTH'(k);
      end
      hdr = (neg ? SIGN_BIT_MASK : 8'h00)
          | ({4'b0, mag[NIBBLE_WIDTH-1:0]} & LOW_NIBBLE_MASK)
          | 8'(len_m1 * SIZE_STEP);
   end

   // serialize
   assign last       = idx_ff == IDX_WIDTH'({1'b0, len_ff}) + IDX_WIDTH'(1);
   assign fire       = valid_ff && rsp_ch.ready;
   assign link_ready = !valid_ff || (fire && last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      hdr_in   = hdr_ff;
      pay_in   = pay_ff;
      if (link_ready) begin
         valid_in = link.valid;
         idx_in   = '0;
         len_in   = len_m1;
         hdr_in   = hdr;
         pay_in   = pay;
      end else if (fire) begin
         idx_in = idx_ff + IDX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      len_ff <= len_in;
      hdr_ff <= hdr_in;
      pay_ff <= pay_in;
   end

   assign byte_sel   = LEN_WIDTH'(idx_ff - IDX_WIDTH'(1));
   assign pay_ff_ext = {{NIBBLE_WIDTH{1'b0}}, pay_ff};

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.last_byte = last;
   assign rsp_ch.out_byte  = (idx_ff == '0) ? hdr_ff
                           : pay_ff_ext[{byte_sel, 3'b000} +: BYTE_WIDTH];

endmodule

FILE: rtl/core/delta_varint_time_packer.sv
// delta_varint_time_packer: top level; delta stage feeding the encoder and
// byte serializer. Depends on dvtp_pkg, dvtp_if, dvtp_delta, dvtp_serializer.
`timescale 1ns / 1ps

// Each request carries a signed 64-bit timestamp; the block emits the
// sign/magnitude delta to the previous timestamp (zero after reset) as a
// header byte plus 1 to 8 payload bytes, one byte per response, with
// last_byte on the final one. A request is taken every cycle while the
// pipeline has room; the sustained rate is set by the byte-wide output
// serializer. A request's delta is registered in dvtp_delta, then its
// header byte is registered in the serializer, from which it is output.
module delta_varint_time_packer (
   input  logic       clock,
   input  logic       reset,
   dvtp_req_if.sink   req_ch,
   dvtp_rsp_if.source rsp_ch
);
   import dvtp_pkg::*;

   delta_type link;
   logic      link_ready;

   dvtp_delta u_delta (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .link       (link),
      .link_ready (link_ready)
   );

   dvtp_serializer u_ser (
      .clock      (clock),
      .reset      (reset),
      .link       (link),
      .link_ready (link_ready),
      .rsp_ch     (rsp_ch)
   );

   // stalled delta holds until the serializer takes it
   a_link_hold: assert property (@(posedge clock) disable iff (reset)
      link.valid && !link_ready |=> link.valid && $stable(link.diff))
      else $error("delta dropped or changed while stalled");

   // request side only backs up when the delta stage is stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> link.valid && !link_ready)
      else $error("request ready low without a stalled delta");

   // finishing a request always frees the serializer
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.last_byte |-> link_ready)
      else $error("serializer not freed on last byte");

endmodule

FILE: tb/sv/tb_delta_varint_time_packer.sv
// tb_delta_varint_time_packer: self-checking bench for the delta varint time packer.
// Checks every response byte against a local sign/magnitude delta encoder.
// Depends on dvtp_pkg, dvtp_if and the delta_varint_time_packer RTL.
`timescale 1ns / 1ps

module tb_delta_varint_time_packer;
   import dvtp_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned RANDOM_PER_PHASE = 125;
   localparam logic [TIME_WIDTH-1:0] TIME_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};

   typedef struct {
      logic [BYTE_WIDTH-1:0] value;
      logic                  last;
   } coded_byte_type;

   logic clock;
   logic reset;

   dvtp_req_if req_ch ();
   dvtp_rsp_if rsp_ch ();

   delta_varint_time_packer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [TIME_WIDTH-1:0] pending_times[$];
   coded_byte_type        expected_bytes[$];
   logic [TIME_WIDTH-1:0] encoder_prev_time;
   logic [TIME_WIDTH-1:0] stim_time;
   int unsigned           send_idle_pct;
   int unsigned           recv_stall_pct;
   int unsigned           error_count;
   int unsigned           quiet_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Expected bytes for one accepted request; advances the stored timestamp.
   task automatic encode_delta(input logic [TIME_WIDTH-1:0] now);
      logic [TIME_WIDTH-1:0] diff;
      logic [TIME_WIDTH-1:0] mag;
      logic [TIME_WIDTH-1:0] payload;
      logic                  neg;
      int                    len;
      coded_byte_type        entry;
      diff = now - encoder_prev_time;
      encoder_prev_time = now;
      neg = diff[TIME_WIDTH-1];
      mag = neg ? (64'd0 - diff) : diff;
      payload = mag >> NIBBLE_WIDTH;
      len = PAY_BYTES;
      while (len > 1 && payload[BYTE_WIDTH*(len-1) +: BYTE_WIDTH] == '0)
         len--;
      entry.value = {neg, 3'(len - 1), mag[NIBBLE_WIDTH-1:0]};
      entry.last = 1'b0;
      expected_bytes.push_back(entry);
      for (int k = 0; k < len; k++) begin
         entry.value = payload[BYTE_WIDTH*k +: BYTE_WIDTH];
         entry.last = (k == len - 1);
         expected_bytes.push_back(entry);
      end
   endtask

   task automatic queue_time(input logic [TIME_WIDTH-1:0] t);
      pending_times.push_back(t);
      stim_time = t;
   endtask

   task automatic queue_delta(input logic [TIME_WIDTH-1:0] d);
      queue_time(stim_time + d);
   endtask

   function automatic logic [TIME_WIDTH-1:0] rand_time();
      return {$urandom, $urandom};
   endfunction

   // Mostly deltas of random width and sign, with some jumps, repeats and extremes.
   task automatic queue_random_request();
      logic [TIME_WIDTH-1:0] d;
      int unsigned           w;
      case ($urandom_range(0, 9))
         0: queue_time(rand_time());
         1: queue_delta(64'd0);
         2: begin
            case ($urandom_range(0, 2))
               0: queue_time(TIME_MIN);
               1: queue_time(TIME_MAX);
               default: queue_time(64'd0);
            endcase
         end
         default: begin
            w = $urandom_range(1, TIME_WIDTH);
            d = rand_time();
            if (w < TIME_WIDTH)
               d = d & ((64'd1 << w) - 64'd1);
            if ($urandom_range(0, 1))
               d = 64'd0 - d;
            queue_delta(d);
         end
      endcase
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid)
            encode_delta(req_ch.timestamp);
         if (pending_times.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.timestamp <= pending_times.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      coded_byte_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected response byte %02h last %0b", $time,
                        rsp_ch.out_byte, rsp_ch.last_byte);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_ch.out_byte !== want.value) begin
                  $display("%0t: out_byte expected %02h actual %02h", $time,
                           want.value, rsp_ch.out_byte);
                  error_count++;
               end
               if (rsp_ch.last_byte !== want.last) begin
                  $display("%0t: last_byte expected %0b actual %0b", $time,
                           want.last, rsp_ch.last_byte);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [TIME_WIDTH-1:0] d;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.timestamp = '0;
      rsp_ch.ready = 1'b0;
      encoder_prev_time = '0;
      stim_time = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      error_count = 0;
      quiet_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         if (phase == 0) begin
            // zero delta twice, nibble edges, then each payload length both signs
            queue_delta(64'd0);
            queue_delta(64'd0);
            queue_delta(64'd1);
            queue_delta(-64'd1);
            queue_delta(64'd15);
            queue_delta(-64'd15);
            queue_delta(64'd16);
            queue_delta(-64'd16);
            for (int k = 1; k < PAY_BYTES; k++) begin
               d = 64'd1 << (NIBBLE_WIDTH + BYTE_WIDTH * k);
               queue_delta(d);
               queue_delta(64'd0 - (2 * d - 64'd1));
            end
            // most negative delta and full-range swings
            queue_time(64'd0);
            queue_time(TIME_MIN);
            queue_time(TIME_MAX);
            queue_time(64'd0);
            queue_time(TIME_MAX);
            queue_time(TIME_MIN);
         end
         repeat (RANDOM_PER_PHASE) queue_random_request();
         while (pending_times.size() != 0 || req_ch.valid || expected_bytes.size() != 0)
            @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_bytes.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: delta_varint_time_packer.f
rtl/core/dvtp_pkg.sv
rtl/core/dvtp_if.sv
rtl/core/dvtp_delta.sv
rtl/core/dvtp_serializer.sv
rtl/core/delta_varint_time_packer.sv
tb/sv/tb_delta_varint_time_packer.sv
